// ===== rtl/core/hftw_pkg.sv =====
package hftw_pkg;

	// Field widths fixed by the file format.
	localparam int IDX_W           = 9;
	localparam int SYM_W           = 8;
	localparam int HBC_W           = 11;
	localparam int WIDX_W          = IDX_W + 1;
	localparam int ASM_W           = 24;
	localparam int TAIL_W          = 3;
	localparam int BIT_CNT_W       = 3;
	localparam int TABLE_DEPTH_DEF = 512;

	// One node of the tree as it sits in the node table.
	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] symbol;
	} node_entry_t;

	// Read and write requests from the controller to the node table.
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
		logic              wr_en;
		logic [WIDX_W-1:0] wr_idx;
		node_entry_t       wr_data;
	} ram_req_t;

	// One decoded symbol handed to the output register.
	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} out_push_t;

	// Position within the compressed file.
	typedef enum logic [1:0] {
		PH_ROOT,
		PH_HDR2,
		PH_NODES,
		PH_BITS
	} phase_t;

	// Controller sequencing.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT_RD,
		ST_ROOT_LD,
		ST_ISSUE,
		ST_EVAL,
		ST_FLUSH
	} ctrl_state_t;

endpackage

// ===== rtl/core/hftw_if.sv =====
// Input channel: one byte of the compressed file per transaction.
interface hftw_in_if import hftw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] data_byte;
	logic             final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Output channel: one decoded symbol per transaction.
interface hftw_out_if import hftw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_of_byte;

	modport source (output valid, output symbol, output last_of_byte, input ready);
	modport sink   (input valid, input symbol, input last_of_byte, output ready);
endinterface

// ===== rtl/core/hftw_node_ram.sv =====
module hftw_node_ram import hftw_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ram_req_t    req,
	output node_entry_t rd_data,
	output logic        init_done
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [WIDX_W-1:0] DEPTH_W = WIDX_W'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	node_entry_t mem [TABLE_DEPTH];

	logic [AW-1:0] clr_addr_q;
	logic          init_done_q;
	node_entry_t   rd_data_q;
	logic          rd_ok_q;

	logic          rd_in_range;
	logic          wr_in_range;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	node_entry_t   wr_data;

	// Indexes past the end of the table read as zero and are never written.
	assign rd_in_range = {1'b0, req.rd_idx} < DEPTH_W;
	assign wr_in_range = req.wr_idx < DEPTH_W;

	// The clearing pass owns the write port until every entry is zero.
	always_comb begin
		if (!init_done_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = req.wr_en && wr_in_range;
			wr_addr = req.wr_idx[AW-1:0];
			wr_data = req.wr_data;
		end
	end

	// Clearing pass sequencing after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				init_done_q <= 1'b1;
			end
		end
	end

	// Memory array with a registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_idx[AW-1:0]];
			rd_ok_q   <= rd_in_range;
		end
	end

	assign rd_data   = rd_ok_q ? rd_data_q : '0;
	assign init_done = init_done_q;

endmodule

// ===== rtl/core/hftw_ctrl.sv =====
module hftw_ctrl import hftw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] data_byte,
	input  logic             final_byte,
	input  logic             init_done,
	input  node_entry_t      rd_data,
	output ram_req_t         ram_req,
	input  logic             out_free,
	output out_push_t        push
);

	ctrl_state_t          state_q, state_d;
	phase_t               phase_q;
	logic [HBC_W-1:0]     hbc_q;
	logic [IDX_W-1:0]     root_q;
	logic [TAIL_W-1:0]    tail_q;
	logic [ASM_W-1:0]     asm_q;
	node_entry_t          cur_entry_q;
	node_entry_t          root_entry_q;
	logic [SYM_W-1:0]     byte_q;
	logic [BIT_CNT_W-1:0] bits_left_q;
	logic                 pend_valid_q;
	logic [SYM_W-1:0]     pend_sym_q;

	logic             in_acc;
	logic [IDX_W-1:0] root_hdr2;
	logic [HBC_W-1:0] hbc_inc;
	logic             nodes_done;
	logic             ev_leaf;
	logic             eval_stall;
	logic             eval_go;
	node_entry_t      next_entry;
	node_entry_t      walk_src;
	logic             walk_bit;
	logic [IDX_W-1:0] child_idx;

	assign in_acc     = in_valid && in_ready;
	assign root_hdr2  = {root_q[IDX_W-1:1], data_byte[SYM_W-1]};
	assign hbc_inc    = hbc_q + HBC_W'(1);
	assign nodes_done = hbc_inc == {root_q, 2'b00};

	// Leaf test on the entry just read; a leaf sends the walk back to the root.
	assign ev_leaf    = (rd_data.left == '0) && (rd_data.right == '0);
	assign eval_stall = ev_leaf && pend_valid_q && !out_free;
	assign eval_go    = (state_q == ST_EVAL) && !eval_stall;
	assign next_entry = ev_leaf ? root_entry_q : rd_data;

	// Child selection for the next read: first bit from the held entry,
	// later bits from the entry that the current read settles on.
	always_comb begin
		if (state_q == ST_ISSUE) begin
			walk_src = cur_entry_q;
			walk_bit = byte_q[SYM_W-1];
		end else begin
			walk_src = next_entry;
			walk_bit = byte_q[SYM_W-2];
		end
		child_idx = walk_bit ? walk_src.right : walk_src.left;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (phase_q)
						PH_ROOT:  state_d = ST_IDLE;
						PH_HDR2:  state_d = (root_hdr2 == '0) ? ST_ROOT_RD : ST_IDLE;
						PH_NODES: state_d = nodes_done ? ST_ROOT_RD : ST_IDLE;
						PH_BITS:  state_d = ST_ISSUE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ROOT_RD: state_d = ST_ROOT_LD;
			ST_ROOT_LD: state_d = ST_IDLE;
			ST_ISSUE:   state_d = ST_EVAL;
			ST_EVAL: begin
				if (eval_go && bits_left_q == '0) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshake, table requests and symbol pushes.
	always_comb begin
		in_ready        = (state_q == ST_IDLE) && init_done;
		ram_req.rd_en   = (state_q == ST_ROOT_RD) || (state_q == ST_ISSUE) ||
		                  (eval_go && bits_left_q != '0);
		ram_req.rd_idx  = (state_q == ST_ROOT_RD) ? root_q : child_idx;
		ram_req.wr_en   = in_acc && (phase_q == PH_NODES) && (hbc_q[1:0] == 2'b11);
		ram_req.wr_idx  = WIDX_W'(hbc_q[HBC_W-1:2]) + WIDX_W'(1);
		ram_req.wr_data = '{left:   asm_q[23:15],
		                    right:  asm_q[14:6],
		                    symbol: data_byte};
		push            = '0;
		if (eval_go && ev_leaf && pend_valid_q) begin
			push = '{valid: 1'b1, symbol: pend_sym_q, last: 1'b0};
		end else if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
			push = '{valid: 1'b1, symbol: pend_sym_q, last: 1'b1};
		end
	end

	// Header parsing, walk state and the symbol held back until its last flag is known.
	// A final byte sends the parser back to the start of a new header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_ROOT;
			hbc_q        <= '0;
			root_q       <= '0;
			tail_q       <= '0;
			asm_q        <= '0;
			cur_entry_q  <= '0;
			root_entry_q <= '0;
			byte_q       <= '0;
			bits_left_q  <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				case (phase_q)
					PH_ROOT: begin
						root_q  <= {data_byte, 1'b0};
						phase_q <= final_byte ? PH_ROOT : PH_HDR2;
						if (final_byte) begin
							hbc_q <= '0;
						end
					end
					PH_HDR2: begin
						root_q <= root_hdr2;
						tail_q <= data_byte[6:4];
						hbc_q  <= '0;
						asm_q  <= '0;
						if (final_byte) begin
							phase_q <= PH_ROOT;
						end else begin
							phase_q <= (root_hdr2 == '0) ? PH_BITS : PH_NODES;
						end
					end
					PH_NODES: begin
						if (hbc_q[1:0] != 2'b11) begin
							asm_q <= {asm_q[ASM_W-SYM_W-1:0], data_byte};
						end
						hbc_q <= final_byte ? '0 : hbc_inc;
						if (final_byte) begin
							phase_q <= PH_ROOT;
						end else if (nodes_done) begin
							phase_q <= PH_BITS;
						end
					end
					default: begin
						byte_q      <= data_byte;
						bits_left_q <= final_byte ? (3'd7 - tail_q) : 3'd7;
						if (final_byte) begin
							phase_q <= PH_ROOT;
							hbc_q   <= '0;
						end
					end
				endcase
			end
			if (state_q == ST_ROOT_LD) begin
				root_entry_q <= rd_data;
				cur_entry_q  <= rd_data;
			end
			if (eval_go) begin
				cur_entry_q <= next_entry;
				byte_q      <= {byte_q[SYM_W-2:0], 1'b0};
				if (bits_left_q != '0) begin
					bits_left_q <= bits_left_q - BIT_CNT_W'(1);
				end
				if (ev_leaf) begin
					pend_valid_q <= 1'b1;
					pend_sym_q   <= rd_data.symbol;
				end
			end
			if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/huffman_tree_walk_decoder.sv =====
// Huffman decoder that walks a node table one bit per cycle unless sym_out stalls.
// byte_in carries the compressed file one byte per transaction: two header bytes
// (root index and node count, unused bit count of the final byte), the node
// entries of four bytes each, then the bitstream, MSB first. final_byte ends a
// file; the next byte starts a new header while the table keeps its contents.
// sym_out carries one decoded symbol per transaction; last_of_byte marks the
// last symbol that an input byte produced. A byte that reaches no leaf gives
// no transaction.
// The last header byte or node entry leads to ST_ROOT_RD and ST_ROOT_LD, which
// load the root entry. A bitstream byte is taken in ST_IDLE, ST_ISSUE issues
// the first node-table read, ST_EVAL tests one read per bit through the single
// read port, and ST_FLUSH hands off the last symbol.
// After reset the node table is cleared one entry per cycle, with byte_in.ready
// low. A stalled sym_out holds its symbol in the output register; the walk goes
// on while a second symbol waits and stops at the next leaf until the receiver
// takes the first.
module huffman_tree_walk_decoder import hftw_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hftw_in_if.sink     byte_in,
	hftw_out_if.source  sym_out
);

	ram_req_t    ram_req;
	node_entry_t rd_data;
	logic        init_done;
	out_push_t   push;
	logic        out_free;

	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_last_q;

	hftw_node_ram #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_node_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.rd_data  (rd_data),
		.init_done(init_done)
	);

	hftw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_in.valid),
		.in_ready  (byte_in.ready),
		.data_byte (byte_in.data_byte),
		.final_byte(byte_in.final_byte),
		.init_done (init_done),
		.rd_data   (rd_data),
		.ram_req   (ram_req),
		.out_free  (out_free),
		.push      (push)
	);

	// Output register: takes a new symbol when empty or when being drained.
	assign out_free = !out_valid_q || sym_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && push.valid) begin
			out_sym_q  <= push.symbol;
			out_last_q <= push.last;
		end
	end

	assign sym_out.valid        = out_valid_q;
	assign sym_out.symbol       = out_sym_q;
	assign sym_out.last_of_byte = out_last_q;

endmodule

// ===== rtl/core/hftw_checker.sv =====
module hftw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_symbol,
	input logic       out_last
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled symbol stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sym_out.valid dropped while stalled");

	// A stalled symbol keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
		else $error("sym_out payload changed while stalled");

	// The table clearing pass keeps the input closed right after reset.
	a_clear_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("byte_in.ready high during the clearing pass");

	// A symbol needs at least one table read after a byte is taken.
	a_no_instant_sym: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("symbol appeared without a table read");

endmodule

bind huffman_tree_walk_decoder hftw_checker u_hftw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_in.valid),
	.in_ready  (byte_in.ready),
	.out_valid (sym_out.valid),
	.out_ready (sym_out.ready),
	.out_symbol(sym_out.symbol),
	.out_last  (sym_out.last_of_byte)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench import hftw_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int TARGET_BYTES = 480;

	// Symbol expected from the decoder for one output transaction.
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} decoded_t;

	// Tracks the decoder state and the symbols it still owes.
	class decode_scoreboard;
		phase_t           file_phase;
		logic [HBC_W-1:0] entry_bytes;
		logic [IDX_W-1:0] root;
		logic [TAIL_W-1:0] tail_skip;
		logic [ASM_W-1:0] partial_entry;
		logic [IDX_W-1:0] walk_node;
		node_entry_t      nodes[TABLE_DEPTH_DEF];
		decoded_t         pending[$];
		int               errors;
		int               checked;

		function new();
			file_phase = PH_ROOT;
			entry_bytes = '0;
			root = '0;
			tail_skip = '0;
			partial_entry = '0;
			walk_node = '0;
			foreach (nodes[i])
				nodes[i] = '0;
			errors = 0;
			checked = 0;
		endfunction

		function node_entry_t fetch(int unsigned idx);
			if (idx < TABLE_DEPTH_DEF)
				return nodes[idx];
			return '0;
		endfunction

		// Advance the model by one accepted byte and queue the symbols it yields.
		function void note_byte(logic [7:0] b, logic fin);
			int unsigned     nbits;
			int unsigned     idx;
			int              produced;
			node_entry_t     here;
			node_entry_t     child;
			logic [IDX_W-1:0] next_idx;

			produced = 0;
			case (file_phase)
				PH_ROOT: begin
					root = {b, 1'b0};
					file_phase = PH_HDR2;
				end
				PH_HDR2: begin
					root[0] = b[7];
					tail_skip = b[6:4];
					entry_bytes = '0;
					partial_entry = '0;
					if (root == '0) begin
						file_phase = PH_BITS;
						walk_node = root;
					end else begin
						file_phase = PH_NODES;
					end
				end
				PH_NODES: begin
					if (entry_bytes[1:0] != 2'd3) begin
						partial_entry = {partial_entry[15:0], b};
					end else begin
						idx = entry_bytes[HBC_W-1:2] + 1;
						if (idx < TABLE_DEPTH_DEF)
							nodes[idx] = '{left: partial_entry[23:15],
								right: partial_entry[14:6], symbol: b};
					end
					entry_bytes = entry_bytes + 1'b1;
					if (entry_bytes == {root, 2'b00}) begin
						file_phase = PH_BITS;
						walk_node = root;
					end
				end
				default: begin
					nbits = fin ? 8 - tail_skip : 8;
					for (int i = 0; i < nbits; i++) begin
						here = fetch(walk_node);
						next_idx = b[7 - i] ? here.right : here.left;
						child = fetch(next_idx);
						if (child.left == '0 && child.right == '0) begin
							pending.insert(pending.size(),
								decoded_t'{symbol: child.symbol, last: 1'b0});
							produced++;
							next_idx = root;
						end
						walk_node = next_idx;
					end
					if (produced > 0)
						pending[pending.size() - 1].last = 1'b1;
				end
			endcase

			// A final byte always sends the decoder back to a new header.
			if (fin) begin
				file_phase = PH_ROOT;
				entry_bytes = '0;
			end
		endfunction

		// Compare one output transaction with the oldest expected symbol.
		function void check_symbol(logic [SYM_W-1:0] sym, logic last);
			decoded_t want;

			if (pending.size() == 0) begin
				$error("unexpected output transaction: symbol %0d last_of_byte %0d", sym, last);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (sym !== want.symbol) begin
				$error("symbol: expected %0d, actual %0d", want.symbol, sym);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_byte: expected %0d, actual %0d", want.last, last);
				errors++;
			end
		endfunction
	endclass

	bit         clk = 1'b0;
	logic       arst_n;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         bytes_sent;
	int         files_sent;
	int         cycle_count = 0;
	logic [7:0] file_img[$];

	decode_scoreboard sb;

	hftw_in_if  byte_in ();
	hftw_out_if sym_out ();

	huffman_tree_walk_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.sym_out (sym_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver backpressure.
	always @(posedge clk) begin
		sym_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check output transactions first, then feed the accepted input to the model.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sym_out.valid && sym_out.ready)
				sb.check_symbol(sym_out.symbol, sym_out.last_of_byte);
			if (byte_in.valid && byte_in.ready)
				sb.note_byte(byte_in.data_byte, byte_in.final_byte);
		end
	end

	// Offer one byte, with random idle cycles ahead of it, and wait for acceptance.
	task automatic put_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.final_byte <= fin;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Send the first cut bytes of the file image, the last one flagged final.
	task automatic send_image(input int unsigned cut);
		for (int unsigned k = 0; k < cut; k++)
			put_byte(file_img[k], k == cut - 1);
		files_sent++;
	endtask

	// Build a well-formed file: random tree with the root as the last entry,
	// followed by a random bitstream.
	function automatic void build_tree_file(int unsigned leaves, int unsigned stream_len);
		node_entry_t      ents[$];
		int unsigned      pool[$];
		int unsigned      pos;
		int unsigned      a;
		int unsigned      c;
		logic [IDX_W-1:0] root;
		logic [31:0]      word;

		file_img.delete();
		ents.insert(0, '0);
		for (int unsigned k = 1; k <= leaves; k++) begin
			ents.insert(ents.size(), node_entry_t'{left: '0, right: '0, symbol: 8'($urandom)});
			pool.insert(pool.size(), k);
		end
		while (pool.size() > 1) begin
			pos = $urandom_range(pool.size() - 1);
			a = pool[pos];
			pool.delete(pos);
			pos = $urandom_range(pool.size() - 1);
			c = pool[pos];
			pool.delete(pos);
			// Now and then point a branch at index zero, which reads as a leaf.
			if ($urandom_range(15) == 0)
				a = 0;
			ents.insert(ents.size(),
				node_entry_t'{left: 9'(a), right: 9'(c), symbol: 8'($urandom)});
			pool.insert(pool.size(), ents.size() - 1);
		end
		root = 9'(ents.size() - 1);
		file_img.insert(file_img.size(), root[8:1]);
		file_img.insert(file_img.size(), {root[0], 3'($urandom), 4'($urandom)});
		for (int unsigned k = 1; k <= root; k++) begin
			word = {ents[k].left, ents[k].right, 6'($urandom), ents[k].symbol};
			file_img.insert(file_img.size(), word[31:24]);
			file_img.insert(file_img.size(), word[23:16]);
			file_img.insert(file_img.size(), word[15:8]);
			file_img.insert(file_img.size(), word[7:0]);
		end
		for (int unsigned k = 0; k < stream_len; k++)
			file_img.insert(file_img.size(), 8'($urandom));
	endfunction

	initial begin
		int unsigned pick;
		int unsigned leaves;

		sb = new();
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		files_sent = 0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		byte_in.final_byte = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Empty tree: every bit lands on the zero leaf, eight symbols per byte.
		file_img = '{8'h00, 8'h0F, 8'h00, 8'hFF};
		send_image(4);
		// Empty tree with seven unused bits in the final byte.
		file_img = '{8'h00, 8'h70, 8'hAA};
		send_image(3);
		// Root that is itself a leaf still steps to a child first.
		file_img = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hC3};
		send_image(7);
		// Largest node count, cut short right after the first node entry.
		file_img = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_image(6);

		// Random files: mostly well-formed, with broken ones and noise mixed in.
		while (bytes_sent < TARGET_BYTES) begin
			case (bytes_sent * 4 / TARGET_BYTES)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			pick = $urandom_range(99);
			leaves = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
			if (pick < 75) begin
				build_tree_file(leaves, $urandom_range(12, 1));
				send_image(file_img.size());
			end else if (pick < 85) begin
				file_img = '{8'h00, {1'b0, 3'($urandom), 4'($urandom)}};
				repeat ($urandom_range(4, 1))
					file_img.insert(file_img.size(), 8'($urandom));
				send_image(file_img.size());
			end else if (pick < 93) begin
				build_tree_file(leaves, $urandom_range(4, 1));
				send_image($urandom_range(file_img.size() - 1, 1));
			end else begin
				file_img.delete();
				repeat ($urandom_range(6, 1))
					file_img.insert(file_img.size(), 8'($urandom));
				send_image(file_img.size());
			end
		end
		byte_in.valid <= 1'b0;
		recv_stall_pct = 0;

		// Drain, then give the decoder time to show any stray output.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d bytes in %0d files, compared %0d decoded symbols.",
			bytes_sent, files_sent, sb.checked);
		$display("Idle and stall mixes: none, sender, receiver, both.");
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
